>>> rtl/core/gtc_pkg.sv
package gtc_pkg;

    localparam int TS_W = 49;
    localparam int LAT_COMPOSE = 7;
    localparam int LAT_SPLIT = 19;
    localparam longint unsigned MS_PER_DAY = 64'd86400000;

    typedef logic [2:0] t_err;

    localparam t_err ERR_NONE  = 3'd0;
    localparam t_err ERR_YEAR  = 3'd1;
    localparam t_err ERR_MONTH = 3'd2;
    localparam t_err ERR_DAY   = 3'd3;
    localparam t_err ERR_TIME  = 3'd4;
    localparam t_err ERR_RANGE = 3'd5;

    typedef struct packed {
        logic [TS_W-1:0] ts;
        t_err            err;
    } t_stamp;

    typedef struct packed {
        logic [TS_W-1:0] ts;
        logic [13:0]     year;
        logic [3:0]      month;
        logic [4:0]      day;
        logic [4:0]      hour;
        logic [5:0]      minute;
        logic [5:0]      second;
        logic [9:0]      milli;
        logic [2:0]      weekday;
        logic [8:0]      yday;
        logic            leap;
        t_err            err;
    } t_result;

    // days in the months before the given one
    function automatic logic [8:0] cum_days(input logic [3:0] month, input logic leap);
        logic [8:0] base;
        case (month)
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        cum_days = base + ((leap && month > 4'd2) ? 9'd1 : 9'd0);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        month_len = len;
    endfunction

endpackage

>>> rtl/core/gtc_dly.sv
module gtc_dly #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_pipe [N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe[0] <= i_d;
            for (int i = 1; i < N; i++) begin
                r_pipe[i] <= r_pipe[i-1];
            end
        end
    end

    assign o_q = r_pipe[N-1];

endmodule

>>> rtl/core/gtc_cdiv.sv
module gtc_cdiv #(
    parameter int W_X = 16,
    parameter int DIV = 10,
    localparam int W_R = $clog2(DIV),
    localparam int W_Q = W_X - W_R + 1
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [W_X-1:0] i_x,
    output logic [W_Q-1:0] o_q,
    output logic [W_R-1:0] o_r
);

    localparam int W_P = W_X + W_Q;
    localparam longint unsigned RECIP_L = (64'd1 << W_X) / DIV;
    localparam logic [W_Q-1:0] RECIP = W_Q'(RECIP_L);

    logic [W_P-1:0] n_prod;
    logic [W_X-1:0] n_rem;
    logic           n_ge;

    logic [W_X-1:0] r_x1;
    logic [W_Q-1:0] r_q1;
    logic [W_Q-1:0] r_q2;
    logic [W_R:0]   r_r2;

    // reciprocal estimate is exact or one low
    assign n_prod = W_P'(i_x) * W_P'(RECIP);
    assign n_rem  = r_x1 - W_X'(r_q1) * W_X'(DIV);
    assign n_ge   = r_r2 >= (W_R+1)'(DIV);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1 <= i_x;
            r_q1 <= n_prod[W_X +: W_Q];
            r_q2 <= r_q1;
            r_r2 <= n_rem[W_R:0];
            o_q  <= n_ge ? r_q2 + W_Q'(1) : r_q2;
            o_r  <= n_ge ? W_R'(r_r2 - (W_R+1)'(DIV)) : r_r2[W_R-1:0];
        end
    end

endmodule

>>> rtl/core/gtc_compose.sv
module gtc_compose #(
    parameter int MAX_YEAR = 9999
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic                 i_cmd,
    input  logic [48:0]          i_timestamp_ms,
    input  logic [13:0]          i_year_in,
    input  logic [3:0]           i_month_in,
    input  logic [4:0]           i_day_in,
    input  logic [4:0]           i_hour_in,
    input  logic [5:0]           i_minute_in,
    input  logic [5:0]           i_second_in,
    input  logic [9:0]           i_milli_in,
    output gtc_pkg::t_stamp      o_stamp
);

    typedef struct packed {
        logic        cmd;
        logic [48:0] ts;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  milli;
    } t_fields;

    t_fields        n_in;
    t_fields        dly;
    logic [7:0]     q100;
    logic [6:0]     r100;
    logic [5:0]     q400;
    logic [8:0]     r400;

    logic           n_leap;
    logic [13:0]    n_p;
    logic [7:0]     n_pd100;
    logic [5:0]     n_pd400;
    logic [22:0]    n_days0;
    gtc_pkg::t_err  n_err;

    logic           r1_cmd;
    logic [48:0]    r1_ts;
    gtc_pkg::t_err  r1_err;
    logic [22:0]    r1_days0;
    logic [8:0]     r1_cum;
    logic [4:0]     r1_day;
    logic [26:0]    r1_hp;
    logic [21:0]    r1_mp;
    logic [15:0]    r1_sp;

    logic           r2_cmd;
    logic [48:0]    r2_ts;
    gtc_pkg::t_err  r2_err;
    logic [22:0]    r2_days;
    logic [26:0]    r2_msd;

    logic           r3_cmd;
    logic [48:0]    r3_ts;
    gtc_pkg::t_err  r3_err;
    logic [48:0]    r3_dm;
    logic [26:0]    r3_msd;

    assign n_in = '{cmd: i_cmd, ts: i_timestamp_ms, year: i_year_in, month: i_month_in,
                    day: i_day_in, hour: i_hour_in, minute: i_minute_in,
                    second: i_second_in, milli: i_milli_in};

    gtc_dly #(.W($bits(t_fields)), .N(3)) u_dly (
        .i_clk (i_clk), .i_en (i_en), .i_d (n_in), .o_q (dly)
    );

    gtc_cdiv #(.W_X(14), .DIV(100)) u_div100 (
        .i_clk (i_clk), .i_en (i_en), .i_x (i_year_in), .o_q (q100), .o_r (r100)
    );

    gtc_cdiv #(.W_X(14), .DIV(400)) u_div400 (
        .i_clk (i_clk), .i_en (i_en), .i_x (i_year_in), .o_q (q400), .o_r (r400)
    );

    always_comb begin
        n_leap  = (dly.year[1:0] == 2'b00) && (r100 != 7'd0 || r400 == 9'd0);
        n_p     = dly.year - 14'd1;
        n_pd100 = (r100 == 7'd0) ? q100 - 8'd1 : q100;
        n_pd400 = (r400 == 9'd0) ? q400 - 6'd1 : q400;
        n_days0 = 23'(n_p) * 23'd365 + 23'(n_p[13:2]) - 23'(n_pd100) + 23'(n_pd400);
        if (dly.year == 14'd0 || 17'(dly.year) > 17'(MAX_YEAR)) begin
            n_err = gtc_pkg::ERR_YEAR;
        end else if (dly.month == 4'd0 || dly.month > 4'd12) begin
            n_err = gtc_pkg::ERR_MONTH;
        end else if (dly.day == 5'd0 ||
                     dly.day > gtc_pkg::month_len(dly.month, n_leap)) begin
            n_err = gtc_pkg::ERR_DAY;
        end else if (dly.hour > 5'd23 || dly.minute > 6'd59 || dly.second > 6'd59 ||
                     dly.milli > 10'd999) begin
            n_err = gtc_pkg::ERR_TIME;
        end else begin
            n_err = gtc_pkg::ERR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_cmd   <= dly.cmd;
            r1_ts    <= dly.ts;
            r1_err   <= n_err;
            r1_days0 <= n_days0;
            r1_cum   <= gtc_pkg::cum_days(dly.month, n_leap);
            r1_day   <= dly.day;
            r1_hp    <= 27'(dly.hour) * 27'd3600000;
            r1_mp    <= 22'(dly.minute) * 22'd60000;
            r1_sp    <= 16'(dly.second) * 16'd1000 + 16'(dly.milli);

            r2_cmd   <= r1_cmd;
            r2_ts    <= r1_ts;
            r2_err   <= r1_err;
            r2_days  <= r1_days0 + 23'(r1_cum) + 23'(r1_day) - 23'd1;
            r2_msd   <= r1_hp + 27'(r1_mp) + 27'(r1_sp);

            r3_cmd   <= r2_cmd;
            r3_ts    <= r2_ts;
            r3_err   <= r2_err;
            r3_dm    <= 49'(r2_days) * 49'(gtc_pkg::MS_PER_DAY);
            r3_msd   <= r2_msd;

            if (!r3_cmd) begin
                o_stamp.ts  <= r3_ts;
                o_stamp.err <= gtc_pkg::ERR_NONE;
            end else if (r3_err != gtc_pkg::ERR_NONE) begin
                o_stamp.ts  <= '0;
                o_stamp.err <= r3_err;
            end else begin
                o_stamp.ts  <= r3_dm + 49'(r3_msd);
                o_stamp.err <= gtc_pkg::ERR_NONE;
            end
        end
    end

endmodule

>>> rtl/core/gtc_split.sv
module gtc_split #(
    parameter int MAX_YEAR = 9999
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  gtc_pkg::t_stamp  i_stamp,
    output gtc_pkg::t_result o_res
);

    localparam longint unsigned PY = 64'(MAX_YEAR);
    localparam longint unsigned LIM_DAYS = PY * 365 + PY / 4 - PY / 100 + PY / 400;
    localparam logic [63:0] LIMIT = LIM_DAYS * gtc_pkg::MS_PER_DAY;

    gtc_pkg::t_stamp n_chk;
    gtc_pkg::t_stamp chk_d;

    logic [9:0]  qa;
    logic [16:0] ra;
    logic [12:0] lo13_d;
    logic [13:0] qb;
    logic [16:0] rb;
    logic [9:0]  lo10_d;
    logic [9:0]  qa_d;
    logic [22:0] days;
    logic [26:0] msd;

    logic [5:0]  n400;
    logic [17:0] r400;
    logic [2:0]  qc;
    logic [15:0] rc;
    logic [1:0]  n_c;
    logic [15:0] n_rc;
    logic [5:0]  q4;
    logic [10:0] r4;
    logic [2:0]  qy;
    logic [8:0]  ry;
    logic [1:0]  n_y1;
    logic [8:0]  n_rd;

    logic [5:0]  n400_d;
    logic [1:0]  c_d;
    logic [5:0]  q4_d;

    logic [20:0] q7;
    logic [2:0]  r7;
    logic [2:0]  r7_d;

    logic [17:0] qs;
    logic [9:0]  ms;
    logic [12:0] qm;
    logic [5:0]  sec;
    logic [7:0]  qh;
    logic [5:0]  mins;
    logic [9:0]  ms_d;
    logic [5:0]  sec_d;
    logic [7:0]  qh_d;
    logic [5:0]  mins_d;

    logic        n_leap;
    logic [3:0]  n_month;
    logic [4:0]  n_day;
    logic [14:0] n_year;

    always_comb begin
        n_chk.ts = i_stamp.ts;
        if (i_stamp.err != gtc_pkg::ERR_NONE) begin
            n_chk.err = i_stamp.err;
        end else if (64'(i_stamp.ts) >= LIMIT) begin
            n_chk.err = gtc_pkg::ERR_RANGE;
        end else begin
            n_chk.err = gtc_pkg::ERR_NONE;
        end
    end

    gtc_dly #(.W($bits(gtc_pkg::t_stamp)), .N(18)) u_dly_chk (
        .i_clk (i_clk), .i_en (i_en), .i_d (n_chk), .o_q (chk_d)
    );

    // ms per day is 1024 * 84375: long division of ts >> 10 as a 26-bit high part, then a 13-bit low digit
    gtc_cdiv #(.W_X(26), .DIV(84375)) u_div_hi (
        .i_clk (i_clk), .i_en (i_en), .i_x (i_stamp.ts[48:23]), .o_q (qa), .o_r (ra)
    );

    gtc_dly #(.W(13), .N(3)) u_dly_lo13 (
        .i_clk (i_clk), .i_en (i_en), .i_d (i_stamp.ts[22:10]), .o_q (lo13_d)
    );

    gtc_cdiv #(.W_X(30), .DIV(84375)) u_div_lo (
        .i_clk (i_clk), .i_en (i_en), .i_x ({ra, lo13_d}), .o_q (qb), .o_r (rb)
    );

    gtc_dly #(.W(10), .N(6)) u_dly_lo10 (
        .i_clk (i_clk), .i_en (i_en), .i_d (i_stamp.ts[9:0]), .o_q (lo10_d)
    );

    gtc_dly #(.W(10), .N(3)) u_dly_qa (
        .i_clk (i_clk), .i_en (i_en), .i_d (qa), .o_q (qa_d)
    );

    assign days = {qa_d, qb[12:0]};
    assign msd  = {rb, lo10_d};

    // calendar: 400-year cycles, centuries, 4-year groups, years
    gtc_cdiv #(.W_X(23), .DIV(146097)) u_div_400y (
        .i_clk (i_clk), .i_en (i_en), .i_x (days), .o_q (n400), .o_r (r400)
    );

    gtc_cdiv #(.W_X(18), .DIV(36524)) u_div_100y (
        .i_clk (i_clk), .i_en (i_en), .i_x (r400), .o_q (qc), .o_r (rc)
    );

    assign n_c  = (qc > 3'd3) ? 2'd3 : qc[1:0];
    assign n_rc = (qc > 3'd3) ? 16'd36524 : rc;

    gtc_cdiv #(.W_X(16), .DIV(1461)) u_div_4y (
        .i_clk (i_clk), .i_en (i_en), .i_x (n_rc), .o_q (q4), .o_r (r4)
    );

    gtc_cdiv #(.W_X(11), .DIV(365)) u_div_1y (
        .i_clk (i_clk), .i_en (i_en), .i_x (r4), .o_q (qy), .o_r (ry)
    );

    assign n_y1 = (qy > 3'd3) ? 2'd3 : qy[1:0];
    assign n_rd = (qy > 3'd3) ? 9'd365 : ry;

    gtc_dly #(.W(6), .N(9)) u_dly_n400 (
        .i_clk (i_clk), .i_en (i_en), .i_d (n400), .o_q (n400_d)
    );

    gtc_dly #(.W(2), .N(6)) u_dly_c (
        .i_clk (i_clk), .i_en (i_en), .i_d (n_c), .o_q (c_d)
    );

    gtc_dly #(.W(6), .N(3)) u_dly_q4 (
        .i_clk (i_clk), .i_en (i_en), .i_d (q4), .o_q (q4_d)
    );

    gtc_cdiv #(.W_X(23), .DIV(7)) u_div_wk (
        .i_clk (i_clk), .i_en (i_en), .i_x (days), .o_q (q7), .o_r (r7)
    );

    gtc_dly #(.W(3), .N(9)) u_dly_wk (
        .i_clk (i_clk), .i_en (i_en), .i_d (r7), .o_q (r7_d)
    );

    // time of day
    gtc_cdiv #(.W_X(27), .DIV(1000)) u_div_ms (
        .i_clk (i_clk), .i_en (i_en), .i_x (msd), .o_q (qs), .o_r (ms)
    );

    gtc_cdiv #(.W_X(18), .DIV(60)) u_div_sec (
        .i_clk (i_clk), .i_en (i_en), .i_x (qs), .o_q (qm), .o_r (sec)
    );

    gtc_cdiv #(.W_X(13), .DIV(60)) u_div_min (
        .i_clk (i_clk), .i_en (i_en), .i_x (qm), .o_q (qh), .o_r (mins)
    );

    gtc_dly #(.W(10), .N(9)) u_dly_ms (
        .i_clk (i_clk), .i_en (i_en), .i_d (ms), .o_q (ms_d)
    );

    gtc_dly #(.W(6), .N(6)) u_dly_sec (
        .i_clk (i_clk), .i_en (i_en), .i_d (sec), .o_q (sec_d)
    );

    gtc_dly #(.W(8), .N(3)) u_dly_hour (
        .i_clk (i_clk), .i_en (i_en), .i_d (qh), .o_q (qh_d)
    );

    gtc_dly #(.W(6), .N(3)) u_dly_min (
        .i_clk (i_clk), .i_en (i_en), .i_d (mins), .o_q (mins_d)
    );

    always_comb begin
        n_leap  = (n_y1 == 2'd3) && (q4_d != 6'd24 || c_d == 2'd3);
        n_month = 4'd1;
        for (int k = 2; k <= 12; k++) begin
            if (n_rd >= gtc_pkg::cum_days(4'(k), n_leap)) begin
                n_month = 4'(k);
            end
        end
        n_day  = 5'(n_rd - gtc_pkg::cum_days(n_month, n_leap) + 9'd1);
        n_year = 15'(n400_d) * 15'd400 + 15'(c_d) * 15'd100 + 15'(q4_d) * 15'd4
                 + 15'(n_y1) + 15'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res.ts  <= chk_d.ts;
            o_res.err <= chk_d.err;
            if (chk_d.err != gtc_pkg::ERR_NONE) begin
                o_res.year    <= '0;
                o_res.month   <= '0;
                o_res.day     <= '0;
                o_res.hour    <= '0;
                o_res.minute  <= '0;
                o_res.second  <= '0;
                o_res.milli   <= '0;
                o_res.weekday <= '0;
                o_res.yday    <= '0;
                o_res.leap    <= 1'b0;
            end else begin
                o_res.year    <= n_year[13:0];
                o_res.month   <= n_month;
                o_res.day     <= n_day;
                o_res.hour    <= qh_d[4:0];
                o_res.minute  <= mins_d;
                o_res.second  <= sec_d;
                o_res.milli   <= ms_d;
                o_res.weekday <= r7_d + 3'd1;
                o_res.yday    <= n_rd + 9'd1;
                o_res.leap    <= n_leap;
            end
        end
    end

endmodule

>>> rtl/core/gregorian_timestamp_converter.sv
// Converts between a millisecond count since 0001-01-01 00:00:00.000 (proleptic
// Gregorian) and calendar fields. cmd 0 splits i_timestamp_ms; cmd 1 validates and
// composes the date and time fields, then reports the full breakdown of the result.
// A beat is taken every cycle while o_stall is low. Each result passes through
// a chain of constant-divider units (day split, then 400/100/4/1-year
// cycles), each three register stages deep. o_stall follows i_stall while a result
// waits, and the whole pipeline holds in place.
module gregorian_timestamp_converter #(
    parameter int MAX_YEAR = 9999
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [48:0] i_timestamp_ms,
    input  logic [13:0] i_year_in,
    input  logic [3:0]  i_month_in,
    input  logic [4:0]  i_day_in,
    input  logic [4:0]  i_hour_in,
    input  logic [5:0]  i_minute_in,
    input  logic [5:0]  i_second_in,
    input  logic [9:0]  i_milli_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [48:0] o_timestamp_out,
    output logic [13:0] o_year_out,
    output logic [3:0]  o_month_out,
    output logic [4:0]  o_day_out,
    output logic [4:0]  o_hour_out,
    output logic [5:0]  o_minute_out,
    output logic [5:0]  o_second_out,
    output logic [9:0]  o_milli_out,
    output logic [2:0]  o_weekday,
    output logic [8:0]  o_year_day,
    output logic        o_leap_flag,
    output logic [2:0]  o_error_code
);

    localparam int LAT = gtc_pkg::LAT_COMPOSE + gtc_pkg::LAT_SPLIT;

    logic             en;
    logic [LAT-1:0]   r_vld;
    gtc_pkg::t_stamp  stamp;
    gtc_pkg::t_result res;

    assign en      = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    gtc_compose #(.MAX_YEAR(MAX_YEAR)) u_compose (
        .i_clk          (i_clk),
        .i_en           (en),
        .i_cmd          (i_cmd),
        .i_timestamp_ms (i_timestamp_ms),
        .i_year_in      (i_year_in),
        .i_month_in     (i_month_in),
        .i_day_in       (i_day_in),
        .i_hour_in      (i_hour_in),
        .i_minute_in    (i_minute_in),
        .i_second_in    (i_second_in),
        .i_milli_in     (i_milli_in),
        .o_stamp        (stamp)
    );

    gtc_split #(.MAX_YEAR(MAX_YEAR)) u_split (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_stamp (stamp),
        .o_res   (res)
    );

    assign o_timestamp_out = res.ts;
    assign o_year_out      = res.year;
    assign o_month_out     = res.month;
    assign o_day_out       = res.day;
    assign o_hour_out      = res.hour;
    assign o_minute_out    = res.minute;
    assign o_second_out    = res.second;
    assign o_milli_out     = res.milli;
    assign o_weekday       = res.weekday;
    assign o_year_day      = res.yday;
    assign o_leap_flag     = res.leap;
    assign o_error_code    = res.err;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_code != gtc_pkg::ERR_NONE |->
            o_month_out == 4'd0 && o_weekday == 3'd0 && o_year_day == 9'd0)
        else $error("error result carries calendar fields");

    a_ok_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_code == gtc_pkg::ERR_NONE |->
            o_month_out != 4'd0 && o_month_out <= 4'd12 && o_day_out != 5'd0)
        else $error("month or day out of range");

    a_ok_week: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_code == gtc_pkg::ERR_NONE |->
            o_weekday != 3'd0 && o_year_day != 9'd0 && o_hour_out <= 5'd23)
        else $error("weekday, year day or hour out of range");

endmodule

>>> tb/gregorian_timestamp_converter_tb.sv
module gregorian_timestamp_converter_tb;

    localparam int MAXY = 9999;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES = 60;
    localparam int HOLD_CYCLES = 150;

    typedef struct packed {
        logic            cmd;
        logic [48:0]     ts;
        logic [13:0]     year;
        logic [3:0]      month;
        logic [4:0]      day;
        logic [4:0]      hour;
        logic [5:0]      minute;
        logic [5:0]      second;
        logic [9:0]      milli;
    } t_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_cmd = 1'b0;
    logic [48:0] i_timestamp_ms = '0;
    logic [13:0] i_year_in = '0;
    logic [3:0]  i_month_in = '0;
    logic [4:0]  i_day_in = '0;
    logic [4:0]  i_hour_in = '0;
    logic [5:0]  i_minute_in = '0;
    logic [5:0]  i_second_in = '0;
    logic [9:0]  i_milli_in = '0;
    logic        o_valid;
    logic        i_stall = 1'b1;
    logic [48:0] o_timestamp_out;
    logic [13:0] o_year_out;
    logic [3:0]  o_month_out;
    logic [4:0]  o_day_out;
    logic [4:0]  o_hour_out;
    logic [5:0]  o_minute_out;
    logic [5:0]  o_second_out;
    logic [9:0]  o_milli_out;
    logic [2:0]  o_weekday;
    logic [8:0]  o_year_day;
    logic        o_leap_flag;
    logic [2:0]  o_error_code;

    gregorian_timestamp_converter #(.MAX_YEAR(MAXY)) i_dut (.*);

    always #6 i_clk = ~i_clk;

    t_req             pending_beats[$];
    gtc_pkg::t_result expected_dates[$];
    int      errors = 0;
    int      n_split = 0, n_compose = 0, n_err = 0, n_checked = 0;
    bit      src_quiet = 1'b0;
    bit      sink_quiet = 1'b0;
    bit      sink_hold = 1'b0;
    int      hold_cnt = 0;
    int      idle_cycles = 0;

    function automatic bit is_leap(longint unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic longint unsigned mdays(longint unsigned y, longint unsigned m);
        if (m == 0 || m > 12) return 0;
        if (m == 2) return is_leap(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
        return 31;
    endfunction

    function automatic longint unsigned days_to_jan1(longint unsigned y);
        longint unsigned p;
        p = y - 1;
        return p * 365 + p / 4 - p / 100 + p / 400;
    endfunction

    function automatic gtc_pkg::t_result split_stamp(longint unsigned ts);
        gtc_pkg::t_result r;
        longint unsigned days, msd, rem, yr, c, q, y1, m;
        r = '0;
        days = ts / gtc_pkg::MS_PER_DAY;
        msd = ts % gtc_pkg::MS_PER_DAY;
        rem = days % 146097;
        yr = (days / 146097) * 400;
        c = rem / 36524;
        if (c > 3) c = 3;
        rem -= c * 36524;
        q = rem / 1461;
        rem -= q * 1461;
        y1 = rem / 365;
        if (y1 > 3) y1 = 3;
        rem -= y1 * 365;
        yr += c * 100 + q * 4 + y1 + 1;
        r.yday = 9'(rem + 1);
        m = 1;
        while (m < 12 && rem >= mdays(yr, m)) begin
            rem -= mdays(yr, m);
            m++;
        end
        r.ts = 49'(ts);
        r.year = 14'(yr);
        r.month = 4'(m);
        r.day = 5'(rem + 1);
        r.hour = 5'(msd / 3600000);
        r.minute = 6'((msd / 60000) % 60);
        r.second = 6'((msd / 1000) % 60);
        r.milli = 10'(msd % 1000);
        r.weekday = 3'(days % 7 + 1);
        r.leap = is_leap(yr);
        r.err = gtc_pkg::ERR_NONE;
        return r;
    endfunction

    function automatic gtc_pkg::t_result convert_date(t_req b);
        gtc_pkg::t_result r;
        longint unsigned days;
        r = '0;
        if (!b.cmd) begin
            if (b.ts >= days_to_jan1(MAXY + 1) * gtc_pkg::MS_PER_DAY) begin
                r.ts = b.ts;
                r.err = gtc_pkg::ERR_RANGE;
                return r;
            end
            return split_stamp(b.ts);
        end
        if (b.year == 0 || b.year > MAXY) r.err = gtc_pkg::ERR_YEAR;
        else if (b.month == 0 || b.month > 12) r.err = gtc_pkg::ERR_MONTH;
        else if (b.day == 0 || b.day > mdays(b.year, b.month)) r.err = gtc_pkg::ERR_DAY;
        else if (b.hour > 23 || b.minute > 59 || b.second > 59 || b.milli > 999)
            r.err = gtc_pkg::ERR_TIME;
        if (r.err != gtc_pkg::ERR_NONE) return r;
        days = days_to_jan1(b.year);
        for (int i = 1; i < b.month; i++) days += mdays(b.year, i);
        days += b.day - 1;
        return split_stamp(days * gtc_pkg::MS_PER_DAY + b.hour * 64'd3600000
                           + b.minute * 64'd60000 + b.second * 64'd1000 + b.milli);
    endfunction

    // driver
    int src_gap = 0;
    always @(posedge i_clk) begin
        t_req b;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_dates.push_back(convert_date(pending_beats.pop_front()));
            end
            if (i_valid && o_stall) begin
            end else if (src_gap > 0 && !src_quiet) begin
                src_gap <= src_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                if (!src_quiet && $urandom_range(0, 7) == 0)
                    src_gap <= $urandom_range(1, 16);
                b = pending_beats[0];
                i_valid <= 1'b1;
                i_cmd <= b.cmd;
                i_timestamp_ms <= b.ts;
                i_year_in <= b.year;
                i_month_in <= b.month;
                i_day_in <= b.day;
                i_hour_in <= b.hour;
                i_minute_in <= b.minute;
                i_second_in <= b.second;
                i_milli_in <= b.milli;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall
    int sink_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b1;
        end else if (sink_hold) begin
            i_stall <= 1'b1;
            if (hold_cnt >= HOLD_CYCLES - 1) begin
                hold_cnt <= 0;
                sink_hold <= 1'b0;
            end else begin
                hold_cnt <= hold_cnt + 1;
            end
        end else if (sink_quiet) begin
            i_stall <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            sink_gap <= $urandom_range(0, 15);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        gtc_pkg::t_result exp_r, got;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_timestamp_out, o_year_out, o_month_out, o_day_out, o_hour_out,
                   o_minute_out, o_second_out, o_milli_out, o_weekday, o_year_day,
                   o_leap_flag, o_error_code};
            if (expected_dates.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
            end else begin
                exp_r = expected_dates.pop_front();
                n_checked++;
                if (exp_r.err != gtc_pkg::ERR_NONE) n_err++;
                if (got.ts !== exp_r.ts || got.year !== exp_r.year ||
                    got.month !== exp_r.month || got.day !== exp_r.day ||
                    got.hour !== exp_r.hour || got.minute !== exp_r.minute ||
                    got.second !== exp_r.second || got.milli !== exp_r.milli ||
                    got.weekday !== exp_r.weekday || got.yday !== exp_r.yday ||
                    got.leap !== exp_r.leap || got.err !== exp_r.err) begin
                    $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic t_req compose_beat(int y, int m, int d, int h, int mi, int s, int ms);
        t_req b;
        b = '0;
        b.cmd = 1'b1;
        b.ts = 49'({$urandom, $urandom});
        b.year = 14'(y);
        b.month = 4'(m);
        b.day = 5'(d);
        b.hour = 5'(h);
        b.minute = 6'(mi);
        b.second = 6'(s);
        b.milli = 10'(ms);
        return b;
    endfunction

    function automatic t_req split_beat(longint unsigned ts);
        t_req b;
        b = {5'($urandom), $urandom, $urandom, $urandom};
        b.cmd = 1'b0;
        b.ts = 49'(ts);
        return b;
    endfunction

    function automatic t_req random_beat();
        t_req b;
        longint unsigned lim;
        int y, m;
        lim = days_to_jan1(MAXY + 1) * gtc_pkg::MS_PER_DAY;
        case ($urandom_range(0, 9))
            0: b = {5'($urandom), $urandom, $urandom, $urandom};
            1: b = split_beat(lim - 1 + $urandom_range(0, 3000));
            2, 3, 4: b = split_beat(({$urandom, $urandom} & 49'h1FFFFFFFFFFFF) % lim);
            5: b = split_beat(longint'($urandom_range(0, 3)) * 146097 * gtc_pkg::MS_PER_DAY
                              + $urandom_range(0, 2000000000) - 1000000000
                              + gtc_pkg::MS_PER_DAY * 5);
            default: begin
                y = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383)
                                                : $urandom_range(1, MAXY);
                m = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                : $urandom_range(1, 12);
                b = compose_beat(y, m, $urandom_range(1, mdays(y, m) + 1),
                                 $urandom_range(0, 24), $urandom_range(0, 60),
                                 $urandom_range(0, 60), $urandom_range(0, 1000));
                if ($urandom_range(0, 15) == 0) begin
                    b.day = 5'($urandom_range(0, 31));
                    b.hour = 5'($urandom_range(0, 31));
                    b.minute = 6'($urandom_range(0, 63));
                    b.second = 6'($urandom_range(0, 63));
                    b.milli = 10'($urandom_range(0, 1023));
                end
            end
        endcase
        return b;
    endfunction

    task automatic wait_drained();
        while (pending_beats.size() > 0 || i_valid || expected_dates.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        longint unsigned lim;
        lim = days_to_jan1(MAXY + 1) * gtc_pkg::MS_PER_DAY;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pending_beats.push_back(split_beat(0));
        pending_beats.push_back(split_beat(lim - 1));
        pending_beats.push_back(split_beat(lim));
        pending_beats.push_back(split_beat(49'h1FFFFFFFFFFFF));
        pending_beats.push_back(split_beat(gtc_pkg::MS_PER_DAY * 146097 - 1));
        pending_beats.push_back(split_beat(gtc_pkg::MS_PER_DAY * 146096));
        pending_beats.push_back(compose_beat(1, 1, 1, 0, 0, 0, 0));
        pending_beats.push_back(compose_beat(MAXY, 12, 31, 23, 59, 59, 999));
        pending_beats.push_back(compose_beat(0, 1, 1, 0, 0, 0, 0));
        pending_beats.push_back(compose_beat(16383, 15, 31, 31, 63, 63, 1023));
        pending_beats.push_back(compose_beat(MAXY + 1, 1, 1, 0, 0, 0, 0));
        pending_beats.push_back(compose_beat(2000, 0, 1, 0, 0, 0, 0));
        pending_beats.push_back(compose_beat(2000, 13, 1, 0, 0, 0, 0));
        pending_beats.push_back(compose_beat(2000, 2, 0, 0, 0, 0, 0));
        pending_beats.push_back(compose_beat(2000, 2, 29, 0, 0, 0, 0));
        pending_beats.push_back(compose_beat(1900, 2, 29, 0, 0, 0, 0));
        pending_beats.push_back(compose_beat(2024, 2, 30, 0, 0, 0, 0));
        pending_beats.push_back(compose_beat(2023, 4, 31, 0, 0, 0, 0));
        pending_beats.push_back(compose_beat(2023, 4, 30, 24, 0, 0, 0));
        pending_beats.push_back(compose_beat(2023, 4, 30, 0, 60, 0, 0));
        pending_beats.push_back(compose_beat(2023, 4, 30, 0, 0, 60, 0));
        pending_beats.push_back(compose_beat(2023, 4, 30, 0, 0, 0, 1000));
        pending_beats.push_back(compose_beat(2000, 12, 31, 12, 30, 30, 500));
        pending_beats.push_back(compose_beat(0, 0, 0, 31, 63, 63, 1023));
        wait_drained();

        // long receiver hold so the pipeline backs up
        sink_hold = 1'b1;
        repeat (200) pending_beats.push_back(random_beat());
        wait (!sink_hold);
        wait_drained();

        repeat (1400) pending_beats.push_back(random_beat());
        wait_drained();

        // no idling in the final part
        src_quiet = 1'b1;
        sink_quiet = 1'b1;
        repeat (250) pending_beats.push_back(random_beat());
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("checked %0d results, %0d with error codes, under random stalls",
                 n_checked, n_err);
        if (errors == 0 && expected_dates.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/core/gtc_pkg.sv
rtl/core/gtc_dly.sv
rtl/core/gtc_cdiv.sv
rtl/core/gtc_compose.sv
rtl/core/gtc_split.sv
rtl/core/gregorian_timestamp_converter.sv
tb/gregorian_timestamp_converter_tb.sv
